>>> hdl/sfd_pkg.sv
// Shared types, codes and constants of the start/length/checksum/end frame deframer.
// Depends on nothing; every other file of the block imports it.
package sfd_pkg;

  localparam logic [7:0]  START_FLAG      = 8'h68;
  localparam logic [7:0]  END_FLAG        = 8'h16;
  localparam logic [15:0] MAX_LEN_RESET   = 16'd1016;
  localparam int          CHAN_W          = 3;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_CTRL   = 3'd3,
    PH_DATA   = 3'd4,
    PH_CSUM   = 3'd5,
    PH_ENDF   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TOO_LONG = 3'd1,
    ERR_CHECKSUM = 3'd2,
    ERR_END_FLAG = 3'd3,
    ERR_ZERO_LEN = 3'd4
  } err_t;

  // One result item as it leaves the parser.
  typedef struct packed {
    logic        store_valid;
    logic [15:0] store_index;
    logic [7:0]  store_byte;
    logic        frame_done;
    logic [15:0] frame_length;
    err_t        error_code;
  } sfd_result_t;

endpackage

>>> hdl/sfd_if.sv
// Valid/ready channel interfaces of the deframer: byte input, result output, configuration.
// Depends on sfd_pkg for the channel width.
interface sfd_in_if;
  import sfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [7:0]        data_byte;
  logic [CHAN_W-1:0] channel;

  modport source (output valid, output data_byte, output channel, input ready);
  modport sink   (input valid, input data_byte, input channel, output ready);
endinterface

interface sfd_out_if;
  import sfd_pkg::*;
  logic        valid;
  logic        ready;
  logic        store_valid;
  logic [15:0] store_index;
  logic [7:0]  store_byte;
  logic        frame_done;
  logic [15:0] frame_length;
  logic [2:0]  error_code;

  modport source (output valid, output store_valid, output store_index, output store_byte,
                  output frame_done, output frame_length, output error_code, input ready);
  modport sink   (input valid, input store_valid, input store_index, input store_byte,
                  input frame_done, input frame_length, input error_code, output ready);
endinterface

interface sfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_data_length;

  modport source (output valid, output max_data_length, input ready);
  modport sink   (input valid, input max_data_length, output ready);
endinterface

>>> hdl/sum_checked_frame_deframer_top.sv
// Top level of the frame deframer: channel registers, configuration register, parser.
// Depends on sfd_pkg, the interfaces in sfd_if.sv and sfd_parser.
//
// Usage:
// The in channel carries one received byte and its source channel number per transfer.
// Every input transfer produces exactly one transfer on the out channel, in order. That
// result says whether the byte belongs to the current frame buffer (with its index and
// value), whether it completed a good frame (with the total frame length), and an error
// code when the frame was dropped for an over-limit length, a zero length, a checksum
// mismatch or a bad end flag.
// The cfg channel writes the largest accepted length field; it is always ready. The user
// must write it only while the block is idle; the block itself does not enforce this.
// Path: a byte taken is held in the input register until the parser processes it, and its
// result is written to the output register, from which the out channel shows it.
// Throughput: one byte per cycle while the receiver takes the results.
// When the receiver stalls, the result stays in the output register and one more byte
// waits in the input register; in ready then drops until the result is taken.
// Reset (rst_n low at a clock edge) empties both registers, puts the parser back to
// hunting for the start flag with channel 0 and restores the length limit to 1016.
module sum_checked_frame_deframer_top (
  input  logic      clk,
  input  logic      rst_n,
  sfd_in_if.sink    in_ch,
  sfd_out_if.source out_ch,
  sfd_cfg_if.sink   cfg_ch
);
  import sfd_pkg::*;

  // Configuration register.
  logic [15:0] max_len_r;

  // Input register.
  logic              in_vld_r;
  logic [7:0]        in_byte_r;
  logic [CHAN_W-1:0] in_chan_r;

  // Result register.
  logic        out_vld_r;
  sfd_result_t out_res_r;
  sfd_result_t step_res;

  logic advance;
  logic in_take;

  // The held byte moves on whenever the result register is empty or being emptied.
  assign advance    = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_take    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_ch.valid) begin
      max_len_r <= cfg_ch.max_data_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.data_byte;
      in_chan_r <= in_ch.channel;
    end
  end

  sfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_byte_r),
    .channel   (in_chan_r),
    .max_len   (max_len_r),
    .result    (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.store_valid  = out_res_r.store_valid;
  assign out_ch.store_index  = out_res_r.store_index;
  assign out_ch.store_byte   = out_res_r.store_byte;
  assign out_ch.frame_done   = out_res_r.frame_done;
  assign out_ch.frame_length = out_res_r.frame_length;
  assign out_ch.error_code   = out_res_r.error_code;

endmodule

>>> hdl/sfd_parser.sv
// Frame parser: phase, length, checksum, position and channel state plus one-byte step logic.
// Depends on sfd_pkg; the state advances only on cycles where step is high.
module sfd_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [7:0]                data_byte,
  input  logic [sfd_pkg::CHAN_W-1:0] channel,
  input  logic [15:0]               max_len,
  output sfd_pkg::sfd_result_t      result
);
  import sfd_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [15:0]       pos_r, pos_nxt;
  logic [CHAN_W-1:0] chan_r;

  phase_t      ph;
  logic        keep;
  logic [15:0] len_full;

  assign len_full = {data_byte, len_r[7:0]};

  always_comb begin
    ph        = (channel != chan_r) ? PH_HUNT : phase_r;
    phase_nxt = ph;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    pos_nxt   = pos_r;
    keep      = 1'b0;
    result    = '0;

    case (ph)
      PH_LEN_LO: begin
        len_nxt   = {8'd0, data_byte};
        phase_nxt = PH_LEN_HI;
        keep      = 1'b1;
      end
      PH_LEN_HI: begin
        len_nxt = len_full;
        if (len_full > max_len) begin
          phase_nxt         = PH_HUNT;
          result.error_code = ERR_TOO_LONG;
        end else if (len_full == 16'd0) begin
          phase_nxt         = PH_HUNT;
          result.error_code = ERR_ZERO_LEN;
        end else begin
          phase_nxt = PH_CTRL;
          keep      = 1'b1;
        end
      end
      PH_CTRL: begin
        sum_nxt   = data_byte;
        phase_nxt = (len_r == 16'd1) ? PH_CSUM : PH_DATA;
        keep      = 1'b1;
      end
      PH_DATA: begin
        sum_nxt = sum_r + data_byte;
        // The last data byte sits at buffer index length + 2.
        if (pos_r == len_r + 16'd2) begin
          phase_nxt = PH_CSUM;
        end
        keep = 1'b1;
      end
      PH_CSUM: begin
        if (data_byte == sum_r) begin
          phase_nxt = PH_ENDF;
          keep      = 1'b1;
        end else begin
          phase_nxt         = PH_HUNT;
          result.error_code = ERR_CHECKSUM;
        end
      end
      PH_ENDF: begin
        phase_nxt = PH_HUNT;
        if (data_byte == END_FLAG) begin
          keep                = 1'b1;
          result.frame_done   = 1'b1;
          result.frame_length = pos_r + 16'd1;
        end else begin
          result.error_code = ERR_END_FLAG;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (data_byte == START_FLAG) begin
          phase_nxt = PH_LEN_LO;
          len_nxt   = 16'd0;
          keep      = 1'b1;
        end
      end
    endcase

    if (keep) begin
      // The start flag always lands at index 0, whatever position held before.
      result.store_valid = 1'b1;
      result.store_byte  = data_byte;
      result.store_index = (ph == PH_HUNT) ? 16'd0 : pos_r;
      pos_nxt            = (ph == PH_HUNT) ? 16'd1 : pos_r + 16'd1;
    end
    if (result.frame_done) begin
      pos_nxt = 16'd0;
      len_nxt = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      sum_r   <= '0;
      pos_r   <= '0;
      chan_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      pos_r   <= pos_nxt;
      chan_r  <= channel;
    end
  end

endmodule

>>> hdl/sfd_checker.sv
// Port-level assertions for the frame deframer and the bind that attaches them.
// Depends on sfd_pkg for the error codes and flags; sees only the top level's ports.
module sfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        store_valid,
  input logic [15:0] store_index,
  input logic [7:0]  store_byte,
  input logic        frame_done,
  input logic [15:0] frame_length,
  input logic [2:0]  error_code
);
  import sfd_pkg::*;

  // A stalled result stays valid and keeps its store index and frame length until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(store_index) && $stable(frame_length))
    else $error("stalled result changed");

  // A completed frame stores its end flag, reports no error and has a nonzero length.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |-> store_valid && store_byte == END_FLAG
                               && error_code == ERR_NONE && frame_length != 16'd0)
    else $error("bad frame completion");

  // A dropped byte is never stored, and unused fields read as zero.
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !store_valid |-> store_index == 16'd0 && store_byte == 8'd0 && !frame_done)
    else $error("unused store fields not cleared");

  // The start flag is the only stored byte at index zero.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && store_valid && store_index == 16'd0 |-> store_byte == START_FLAG
                                                          && error_code == ERR_NONE)
    else $error("index zero without start flag");

endmodule

bind sum_checked_frame_deframer_top sfd_checker u_sfd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .store_valid  (out_ch.store_valid),
  .store_index  (out_ch.store_index),
  .store_byte   (out_ch.store_byte),
  .frame_done   (out_ch.frame_done),
  .frame_length (out_ch.frame_length),
  .error_code   (out_ch.error_code)
);
